>>> src/qrv_pkg.sv
// Shared types and constants for the quaternion vector rotation pipeline.
// No dependencies; every module of the block imports this package.
`default_nettype none

package qrv_pkg;

    localparam int NUM_AXES  = 3;
    localparam int NUM_QUAT  = 4;
    localparam int NUM_COEF  = 9;

    // Quaternion component positions
    localparam int Q_R = 0;
    localparam int Q_I = 1;
    localparam int Q_J = 2;
    localparam int Q_K = 3;

    // Vector axis positions
    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    // Coefficients come in rows of three, one row per output axis: the diagonal
    // term first, then the two cross terms. This is the vector axis each one scales.
    localparam int COEF_VEC [NUM_COEF] = '{AX_X, AX_Y, AX_Z,
                                           AX_Y, AX_X, AX_Z,
                                           AX_Z, AX_X, AX_Y};

    // Pipeline control handed to each compute stage module
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

>>> src/qrv_in_if.sv
// Input channel of the rotation block: quaternion and vector with valid/ready.
// Depends on nothing; width set by COORD_WIDTH.
`default_nettype none

interface qrv_in_if #(
    parameter int COORD_WIDTH = 16
) ();

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] quat_real;
    logic signed [COORD_WIDTH-1:0] quat_i;
    logic signed [COORD_WIDTH-1:0] quat_j;
    logic signed [COORD_WIDTH-1:0] quat_k;
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
    logic signed [COORD_WIDTH-1:0] vec_z;

    modport source (
        output valid, quat_real, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z,
        input  ready
    );

    modport sink (
        input  valid, quat_real, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z,
        output ready
    );

endinterface

`default_nettype wire

>>> src/qrv_out_if.sv
// Output channel of the rotation block: rotated vector and overflow flag.
// Depends on nothing; width set by COORD_WIDTH.
`default_nettype none

interface qrv_out_if #(
    parameter int COORD_WIDTH = 16
) ();

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] rot_x;
    logic signed [COORD_WIDTH-1:0] rot_y;
    logic signed [COORD_WIDTH-1:0] rot_z;
    logic                          overflow;

    modport source (
        output valid, rot_x, rot_y, rot_z, overflow,
        input  ready
    );

    modport sink (
        input  valid, rot_x, rot_y, rot_z, overflow,
        output ready
    );

endinterface

`default_nettype wire

>>> src/quaternion_rotate_vector_top.sv
// Quaternion rotation of a vector, v' = q * (0,v) * conj(q), with q in signed
// fixed point of QUAT_FRAC_BITS fraction bits and v at any scale, both
// COORD_WIDTH bits wide. One item is accepted every clock cycle while input ready is
// high; each item is registered in turn as quadratic products, coefficients, split
// partial products, recombination, sum and round, and then in the output register.
// All five compute stages of the pipeline advance together on a single enable that
// drops only while the skid entry behind the output register is occupied, so
// input ready is a registered signal. The result is rounded once to nearest
// (ties upward), saturated per axis, and overflow flags any clamped axis. The
// quaternion is not normalised: a non-unit q scales the result by its norm squared.
// Depends on qrv_pkg, qrv_in_if, qrv_out_if and the qrv_* stage modules.
`default_nettype none

module quaternion_rotate_vector_top #(
    parameter int COORD_WIDTH    = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    qrv_in_if.sink       item_in,
    qrv_out_if.source    result_out
);

    import qrv_pkg::*;

    localparam int CFW = 2 * COORD_WIDTH + 2;
    localparam int TW  = 3 * COORD_WIDTH + 2;

    logic                          pipe_en;
    pipe_ctl_t                     quad_ctl;
    pipe_ctl_t                     scale_ctl;
    pipe_ctl_t                     round_ctl;
    logic signed [COORD_WIDTH-1:0] quat [NUM_QUAT];
    logic signed [COORD_WIDTH-1:0] vec  [NUM_AXES];
    logic                          quad_valid;
    logic signed [CFW-1:0]         coef [NUM_COEF];
    logic signed [COORD_WIDTH-1:0] vec_b [NUM_AXES];
    logic                          scale_valid;
    logic signed [TW-1:0]          term [NUM_COEF];
    logic                          round_valid;
    logic signed [COORD_WIDTH-1:0] round_rot [NUM_AXES];
    logic                          round_ovf;
    logic signed [COORD_WIDTH-1:0] out_rot [NUM_AXES];

    assign quat[Q_R] = item_in.quat_real;
    assign quat[Q_I] = item_in.quat_i;
    assign quat[Q_J] = item_in.quat_j;
    assign quat[Q_K] = item_in.quat_k;
    assign vec[AX_X] = item_in.vec_x;
    assign vec[AX_Y] = item_in.vec_y;
    assign vec[AX_Z] = item_in.vec_z;

    assign item_in.ready = pipe_en;

    assign quad_ctl  = '{en: pipe_en, valid: item_in.valid};
    assign scale_ctl = '{en: pipe_en, valid: quad_valid};
    assign round_ctl = '{en: pipe_en, valid: scale_valid};

    qrv_quad #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_quad (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (quad_ctl),
        .quat    (quat),
        .vec     (vec),
        .valid   (quad_valid),
        .coef    (coef),
        .vec_out (vec_b)
    );

    qrv_scale #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scale_ctl),
        .coef  (coef),
        .vec   (vec_b),
        .valid (scale_valid),
        .term  (term)
    );

    qrv_round #(
        .COORD_WIDTH    (COORD_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (round_ctl),
        .term     (term),
        .valid    (round_valid),
        .rot      (round_rot),
        .overflow (round_ovf)
    );

    qrv_outbuf #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_outbuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (round_valid),
        .in_rot       (round_rot),
        .in_overflow  (round_ovf),
        .advance      (pipe_en),
        .out_valid    (result_out.valid),
        .out_ready    (result_out.ready),
        .out_rot      (out_rot),
        .out_overflow (result_out.overflow)
    );

    assign result_out.rot_x = out_rot[AX_X];
    assign result_out.rot_y = out_rot[AX_Y];
    assign result_out.rot_z = out_rot[AX_Z];

`ifndef ASSERT_OFF
    localparam logic signed [COORD_WIDTH-1:0] ROT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] ROT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // a stalled pipeline always has a result waiting at the output
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !item_in.ready |-> result_out.valid)
        else $error("input stalled with no result held at the output");

    // the skid entry fills only when the output was held back
    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(item_in.ready) |-> $past(result_out.valid && !result_out.ready))
        else $error("skid entry filled without an output stall");

    // a flagged overflow leaves at least one axis on a bound
    a_overflow_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.overflow) |->
            (result_out.rot_x == ROT_MAX || result_out.rot_x == ROT_MIN ||
             result_out.rot_y == ROT_MAX || result_out.rot_y == ROT_MIN ||
             result_out.rot_z == ROT_MAX || result_out.rot_z == ROT_MIN))
        else $error("overflow flagged but no axis saturated");
`endif

endmodule

`default_nettype wire

>>> src/qrv_quad.sv
// Stages one and two: the ten quadratic products of the quaternion and the
// nine rotation-matrix coefficients built from them. Uses qrv_pkg.
`default_nettype none

module qrv_quad #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qrv_pkg::pipe_ctl_t            ctl,
    input  logic signed [COORD_WIDTH-1:0] quat [qrv_pkg::NUM_QUAT],
    input  logic signed [COORD_WIDTH-1:0] vec [qrv_pkg::NUM_AXES],
    output logic                          valid,
    output logic signed [2*COORD_WIDTH+1:0] coef [qrv_pkg::NUM_COEF],
    output logic signed [COORD_WIDTH-1:0] vec_out [qrv_pkg::NUM_AXES]
);

    import qrv_pkg::*;

    localparam int PW  = 2 * COORD_WIDTH;
    localparam int CFW = 2 * COORD_WIDTH + 2;
    localparam int NUM_PROD = 10;

    localparam int P_RR = 0;
    localparam int P_II = 1;
    localparam int P_JJ = 2;
    localparam int P_KK = 3;
    localparam int P_IJ = 4;
    localparam int P_RK = 5;
    localparam int P_IK = 6;
    localparam int P_RJ = 7;
    localparam int P_JK = 8;
    localparam int P_RI = 9;

    logic                          valid_a_reg;
    logic                          valid_b_reg;
    logic signed [PW-1:0]          prod_next [NUM_PROD];
    logic signed [PW-1:0]          prod_reg  [NUM_PROD];
    logic signed [CFW-1:0]         coef_next [NUM_COEF];
    logic signed [CFW-1:0]         coef_reg  [NUM_COEF];
    logic signed [COORD_WIDTH-1:0] vec_a_reg [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] vec_b_reg [NUM_AXES];

    always_comb
    begin
        prod_next[P_RR] = quat[Q_R] * quat[Q_R];
        prod_next[P_II] = quat[Q_I] * quat[Q_I];
        prod_next[P_JJ] = quat[Q_J] * quat[Q_J];
        prod_next[P_KK] = quat[Q_K] * quat[Q_K];
        prod_next[P_IJ] = quat[Q_I] * quat[Q_J];
        prod_next[P_RK] = quat[Q_R] * quat[Q_K];
        prod_next[P_IK] = quat[Q_I] * quat[Q_K];
        prod_next[P_RJ] = quat[Q_R] * quat[Q_J];
        prod_next[P_JK] = quat[Q_J] * quat[Q_K];
        prod_next[P_RI] = quat[Q_R] * quat[Q_I];
    end

    always_comb
    begin
        coef_next[0] = CFW'(prod_reg[P_RR]) + CFW'(prod_reg[P_II])
                     - CFW'(prod_reg[P_JJ]) - CFW'(prod_reg[P_KK]);
        coef_next[1] = CFW'(prod_reg[P_IJ]) - CFW'(prod_reg[P_RK]);
        coef_next[2] = CFW'(prod_reg[P_IK]) + CFW'(prod_reg[P_RJ]);
        coef_next[3] = CFW'(prod_reg[P_RR]) - CFW'(prod_reg[P_II])
                     + CFW'(prod_reg[P_JJ]) - CFW'(prod_reg[P_KK]);
        coef_next[4] = CFW'(prod_reg[P_IJ]) + CFW'(prod_reg[P_RK]);
        coef_next[5] = CFW'(prod_reg[P_JK]) - CFW'(prod_reg[P_RI]);
        coef_next[6] = CFW'(prod_reg[P_RR]) - CFW'(prod_reg[P_II])
                     - CFW'(prod_reg[P_JJ]) + CFW'(prod_reg[P_KK]);
        coef_next[7] = CFW'(prod_reg[P_IK]) - CFW'(prod_reg[P_RJ]);
        coef_next[8] = CFW'(prod_reg[P_JK]) + CFW'(prod_reg[P_RI]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_a_reg <= ctl.valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg  <= prod_next;
            coef_reg  <= coef_next;
            vec_a_reg <= vec;
            vec_b_reg <= vec_a_reg;
        end
    end

    assign valid   = valid_b_reg;
    assign coef    = coef_reg;
    assign vec_out = vec_b_reg;

endmodule

`default_nettype wire

>>> src/qrv_scale.sv
// Stages three and four: each coefficient times its vector axis, split into a
// low and a high partial product, then recombined at full width. Uses qrv_pkg.
`default_nettype none

module qrv_scale #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  qrv_pkg::pipe_ctl_t              ctl,
    input  logic signed [2*COORD_WIDTH+1:0] coef [qrv_pkg::NUM_COEF],
    input  logic signed [COORD_WIDTH-1:0]   vec [qrv_pkg::NUM_AXES],
    output logic                            valid,
    output logic signed [3*COORD_WIDTH+1:0] term [qrv_pkg::NUM_COEF]
);

    import qrv_pkg::*;

    localparam int CFW = 2 * COORD_WIDTH + 2;
    localparam int LW  = COORD_WIDTH + 1;      // low slice, unsigned
    localparam int HW  = CFW - LW;             // high slice, signed
    localparam int LPW = LW + 1 + COORD_WIDTH;
    localparam int HPW = HW + COORD_WIDTH;
    localparam int TW  = 3 * COORD_WIDTH + 2;

    logic                   valid_c_reg;
    logic                   valid_d_reg;
    logic signed [LW:0]     lo_ext   [NUM_COEF];
    logic signed [HW-1:0]   hi_part  [NUM_COEF];
    logic signed [COORD_WIDTH-1:0] vec_sel [NUM_COEF];
    logic signed [LPW-1:0]  lo_prod_next [NUM_COEF];
    logic signed [LPW-1:0]  lo_prod_reg  [NUM_COEF];
    logic signed [HPW-1:0]  hi_prod_next [NUM_COEF];
    logic signed [HPW-1:0]  hi_prod_reg  [NUM_COEF];
    logic signed [TW-1:0]   term_next [NUM_COEF];
    logic signed [TW-1:0]   term_reg  [NUM_COEF];

    always_comb
    begin
        for (int n = 0; n < NUM_COEF; n++)
        begin
            lo_ext[n]       = $signed({1'b0, coef[n][LW-1:0]});
            hi_part[n]      = coef[n][CFW-1:LW];
            vec_sel[n]      = vec[COEF_VEC[n][1:0]];
            lo_prod_next[n] = lo_ext[n] * vec_sel[n];
            hi_prod_next[n] = hi_part[n] * vec_sel[n];
        end
    end

    // Rejoin the slices: high product weighted by the width of the low slice
    always_comb
    begin
        for (int n = 0; n < NUM_COEF; n++)
        begin
            term_next[n] = (TW'(hi_prod_reg[n]) <<< LW) + TW'(lo_prod_reg[n]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_c_reg <= ctl.valid;
            valid_d_reg <= valid_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
            term_reg    <= term_next;
        end
    end

    assign valid = valid_d_reg;
    assign term  = term_reg;

endmodule

`default_nettype wire

>>> src/qrv_round.sv
// Stage five: sum of the three terms per axis plus the rounding offset, then
// the shift back to vector scale and saturation on the way out. Uses qrv_pkg.
`default_nettype none

module qrv_round #(
    parameter int COORD_WIDTH    = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  qrv_pkg::pipe_ctl_t              ctl,
    input  logic signed [3*COORD_WIDTH+1:0] term [qrv_pkg::NUM_COEF],
    output logic                            valid,
    output logic signed [COORD_WIDTH-1:0]   rot [qrv_pkg::NUM_AXES],
    output logic                            overflow
);

    import qrv_pkg::*;

    localparam int SH  = 2 * QUAT_FRAC_BITS;
    localparam int SWA = 3 * COORD_WIDTH + 5;
    localparam int SWB = SH + 2;
    localparam int SW  = (SWA > SWB) ? SWA : SWB;

    localparam logic signed [SW-1:0] HALF     = {{(SW-1){1'b0}}, 1'b1} << (SH - 1);
    localparam logic signed [SW-1:0] SAT_HIGH =
        {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LOW  =
        {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    logic                valid_e_reg;
    logic signed [SW-1:0] sum_next [NUM_AXES];
    logic signed [SW-1:0] sum_reg  [NUM_AXES];
    logic signed [SW-1:0] rnd      [NUM_AXES];
    logic [NUM_AXES-1:0]  clip;

    // Cross terms carry the factor of two from the rotation formula
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sum_next[a] = SW'(term[3*a]) + (SW'(term[3*a+1]) <<< 1)
                        + (SW'(term[3*a+2]) <<< 1) + HALF;
        end
    end

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            rnd[a] = sum_reg[a] >>> SH;
            if (rnd[a] > SAT_HIGH)
            begin
                rot[a]  = SAT_HIGH[COORD_WIDTH-1:0];
                clip[a] = 1'b1;
            end
            else if (rnd[a] < SAT_LOW)
            begin
                rot[a]  = SAT_LOW[COORD_WIDTH-1:0];
                clip[a] = 1'b1;
            end
            else
            begin
                rot[a]  = rnd[a][COORD_WIDTH-1:0];
                clip[a] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_e_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_e_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign valid    = valid_e_reg;
    assign overflow = |clip;

endmodule

`default_nettype wire

>>> src/qrv_outbuf.sv
// Output register with a one-entry skid stage; the pipeline advances whenever
// the skid stage is empty. Uses qrv_pkg.
`default_nettype none

module qrv_outbuf #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] in_rot [qrv_pkg::NUM_AXES],
    input  logic                          in_overflow,
    output logic                          advance,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] out_rot [qrv_pkg::NUM_AXES],
    output logic                          out_overflow
);

    import qrv_pkg::*;

    logic                          out_valid_reg;
    logic                          skid_valid_reg;
    logic signed [COORD_WIDTH-1:0] out_rot_reg  [NUM_AXES];
    logic                          out_ovf_reg;
    logic signed [COORD_WIDTH-1:0] skid_rot_reg [NUM_AXES];
    logic                          skid_ovf_reg;
    logic                          out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg <= in_valid;
            end
            else if (in_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            // drain the skid entry into the output register
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            if (out_free)
            begin
                out_rot_reg <= in_rot;
                out_ovf_reg <= in_overflow;
            end
            else
            begin
                skid_rot_reg <= in_rot;
                skid_ovf_reg <= in_overflow;
            end
        end
        else if (out_ready)
        begin
            out_rot_reg <= skid_rot_reg;
            out_ovf_reg <= skid_ovf_reg;
        end
    end

    assign advance      = !skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_rot      = out_rot_reg;
    assign out_overflow = out_ovf_reg;

endmodule

`default_nettype wire

>>> bench/qrv_checker.sv
// Scoreboard for the quaternion rotation block: watches both channels,
// predicts every rotated vector and compares each result transfer in order.
// Depends on the qrv_in_if and qrv_out_if interfaces.

module qrv_checker #(
    parameter int CW = 16,
    parameter int FB = 14
) (
    input  logic      clk,
    input  logic      rst_n,
    qrv_in_if         item_in,
    qrv_out_if        result_out,
    output int        fail_count,
    output int        pending,
    output int        checked,
    output int        ovf_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 ovf;
    } rot_t;

    localparam logic signed [127:0] HALF = 128'sd1 <<< (2 * FB - 1);
    localparam logic signed [127:0] MAXV = (128'sd1 <<< (CW - 1)) - 128'sd1;
    localparam logic signed [127:0] MINV = -(128'sd1 <<< (CW - 1));

    rot_t rot_expect_q[$];

    // Returns {clamped, value}: round to nearest with ties upward, then clamp
    function automatic logic [CW:0] round_clamp(input logic signed [127:0] acc);
        logic signed [127:0] t;
        t = (acc + HALF) >>> (2 * FB);
        if (t > MAXV)
            return {1'b1, MAXV[CW-1:0]};
        if (t < MINV)
            return {1'b1, MINV[CW-1:0]};
        return {1'b0, t[CW-1:0]};
    endfunction

    function automatic rot_t rotate_vec(
        input logic signed [CW-1:0] qr, qi, qj, qk, vx, vy, vz
    );
        logic signed [127:0] r, i, j, k, x, y, z;
        logic [CW:0]         ax, ay, az;
        rot_t                res;
        r = qr;
        i = qi;
        j = qj;
        k = qk;
        x = vx;
        y = vy;
        z = vz;
        ax = round_clamp(x * (r*r + i*i - j*j - k*k) + 2 * (y * (i*j - r*k) + z * (i*k + r*j)));
        ay = round_clamp(y * (r*r - i*i + j*j - k*k) + 2 * (x * (i*j + r*k) + z * (j*k - r*i)));
        az = round_clamp(z * (r*r - i*i - j*j + k*k) + 2 * (x * (i*k - r*j) + y * (j*k + r*i)));
        res.x   = ax[CW-1:0];
        res.y   = ay[CW-1:0];
        res.z   = az[CW-1:0];
        res.ovf = ax[CW] | ay[CW] | az[CW];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rot_t want;
        int   errs;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
            ovf_seen   <= 0;
        end
        else
        begin
            errs = 0;
            if (item_in.valid && item_in.ready)
                rot_expect_q.push_back(rotate_vec(item_in.quat_real, item_in.quat_i,
                    item_in.quat_j, item_in.quat_k, item_in.vec_x, item_in.vec_y,
                    item_in.vec_z));
            if (result_out.valid && result_out.ready)
            begin
                if (rot_expect_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing outstanding: x %0d y %0d z %0d ovf %0b",
                        $time, result_out.rot_x, result_out.rot_y, result_out.rot_z,
                        result_out.overflow);
                    errs++;
                end
                else
                begin
                    want = rot_expect_q.pop_front();
                    if (result_out.rot_x !== want.x)
                    begin
                        $display("%0t: rot_x expected %0d, got %0d", $time, want.x, result_out.rot_x);
                        errs++;
                    end
                    if (result_out.rot_y !== want.y)
                    begin
                        $display("%0t: rot_y expected %0d, got %0d", $time, want.y, result_out.rot_y);
                        errs++;
                    end
                    if (result_out.rot_z !== want.z)
                    begin
                        $display("%0t: rot_z expected %0d, got %0d", $time, want.z, result_out.rot_z);
                        errs++;
                    end
                    if (result_out.overflow !== want.ovf)
                    begin
                        $display("%0t: overflow expected %0b, got %0b", $time, want.ovf,
                            result_out.overflow);
                        errs++;
                    end
                    checked  <= checked + 1;
                    ovf_seen <= ovf_seen + (want.ovf ? 1 : 0);
                end
            end
            fail_count <= fail_count + errs;
            pending    <= rot_expect_q.size();
        end
    end

endmodule

>>> bench/tb_top.sv
// Stimulus and verdict for quaternion_rotate_vector_top: directed corners, then
// random items under three stall profiles. Depends on qrv_in_if, qrv_out_if,
// qrv_checker and the block itself.

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = 16;
    localparam int FB         = 14;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 24;

    logic clk;
    logic rst_n;
    int   send_idle;
    int   recv_idle;
    int   items_sent;
    int   stall_cycles;
    int   fail_count;
    int   pending;
    int   checked;
    int   ovf_seen;

    qrv_in_if  #(.COORD_WIDTH(CW)) item_if ();
    qrv_out_if #(.COORD_WIDTH(CW)) result_if ();

    quaternion_rotate_vector_top #(
        .COORD_WIDTH    (CW),
        .QUAT_FRAC_BITS (FB)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (result_if)
    );

    qrv_checker #(
        .CW (CW),
        .FB (FB)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (result_if),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .ovf_seen   (ovf_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_MAX);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic signed [CW-1:0] qr, qi, qj, qk, vx, vy, vz);
        while ($urandom_range(99) < send_idle)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.quat_real <= qr;
        item_if.quat_i    <= qi;
        item_if.quat_j    <= qj;
        item_if.quat_k    <= qk;
        item_if.vec_x     <= vx;
        item_if.vec_y     <= vy;
        item_if.vec_z     <= vz;
        do
            @(posedge clk);
        while (!item_if.ready);
        items_sent++;
    endtask

    // Hold the input quiet until every outstanding result has been returned;
    // first let the checker count the last input transfer in pending
    task automatic drain();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] pick_corner();
        case ($urandom_range(7))
            0:       return -16'sd32768;
            1:       return -16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            5:       return 16'sd32767;
            6:       return 16'sd16384;
            default: return -16'sd16384;
        endcase
    endfunction

    // Random rotation of unit norm at Q2.14: i, j, k bounded so that r stays real
    function automatic logic [4*CW-1:0] unit_quat();
        int  a;
        int  b;
        int  c;
        int  r;
        real rem;
        a = int'($urandom_range(18916)) - 9458;
        b = int'($urandom_range(18916)) - 9458;
        c = int'($urandom_range(18916)) - 9458;
        rem = 268435456.0 - real'(a) * a - real'(b) * b - real'(c) * c;
        r = int'($sqrt(rem));
        if ($urandom_range(1))
            r = -r;
        return {r[CW-1:0], a[CW-1:0], b[CW-1:0], c[CW-1:0]};
    endfunction

    task automatic run_random(input int count, input int s_idle, input int r_idle);
        logic signed [CW-1:0] qr, qi, qj, qk, vx, vy, vz;
        int                   sm;
        send_idle = s_idle;
        recv_idle = r_idle;
        repeat (count)
        begin
            vx = CW'($urandom);
            vy = CW'($urandom);
            vz = CW'($urandom);
            case ($urandom_range(9))
                0, 1:
                begin
                    qr = CW'($urandom);
                    qi = CW'($urandom);
                    qj = CW'($urandom);
                    qk = CW'($urandom);
                end
                6, 7:
                begin
                    sm = int'($urandom_range(32768)) - 16384;
                    qr = sm[CW-1:0];
                    sm = int'($urandom_range(32768)) - 16384;
                    qi = sm[CW-1:0];
                    sm = int'($urandom_range(32768)) - 16384;
                    qj = sm[CW-1:0];
                    sm = int'($urandom_range(32768)) - 16384;
                    qk = sm[CW-1:0];
                end
                8:
                begin
                    qr = pick_corner();
                    qi = pick_corner();
                    qj = pick_corner();
                    qk = pick_corner();
                    vx = pick_corner();
                    vy = pick_corner();
                    vz = pick_corner();
                end
                9:
                begin
                    {qr, qi, qj, qk} = unit_quat();
                    vx = pick_corner();
                    vy = pick_corner();
                    vz = pick_corner();
                end
                default:
                    {qr, qi, qj, qk} = unit_quat();
            endcase
            send_item(qr, qi, qj, qk, vx, vy, vz);
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        item_if.valid     <= 1'b0;
        item_if.quat_real <= '0;
        item_if.quat_i    <= '0;
        item_if.quat_j    <= '0;
        item_if.quat_k    <= '0;
        item_if.vec_x     <= '0;
        item_if.vec_y     <= '0;
        item_if.vec_z     <= '0;
        send_idle  = 28;
        recv_idle  = 77;
        items_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // zero quaternion, with a zero and with an extreme vector
        send_item(0, 0, 0, 0, 0, 0, 0);
        send_item(0, 0, 0, 0, 32767, -32768, 1);
        // identity rotation with extreme vectors
        send_item(16384, 0, 0, 0, 32767, -32768, 0);
        send_item(16384, 0, 0, 0, -1, 1, -32767);
        send_item(-16384, 0, 0, 0, 1234, -4321, 32767);
        // quarter turns about each axis, half turns
        send_item(11585, 0, 0, 11585, 10000, 0, 0);
        send_item(11585, 11585, 0, 0, 0, 10000, -5000);
        send_item(11585, 0, 11585, 0, 7000, -3000, 10000);
        send_item(0, 16384, 0, 0, 100, 200, 300);
        send_item(0, 0, 16384, 0, -100, 200, -300);
        send_item(0, 0, 0, 16384, 32767, 32767, 32767);
        // ties at one half: upward for both signs
        send_item(8192, 0, 0, 0, 2, -2, 6);
        send_item(8192, 0, 0, 0, -6, 10, -10);
        // non-unit quaternion scales the vector; saturation on both bounds
        send_item(-32768, 0, 0, 0, 1, -1, 8191);
        send_item(32767, 0, 0, 0, -32768, 32767, 100);
        send_item(32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_item(-32768, -32768, -32768, -32768, 32767, -32768, 32767);
        send_item(32767, -32768, 32767, -32768, -32768, 32767, -32768);
        // results at or just inside the bounds, with no overflow
        send_item(16384, 0, 0, 0, 32767, 1, 0);
        send_item(23170, 0, 0, 0, 16384, 0, 0);
        send_item(23170, 0, 0, 0, 16383, -16384, 16383);
        drain();

        run_random(170, 28, 77);
        drain();
        run_random(170, 77, 28);
        run_random(160, 0, 0);
        drain();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d items (directed corners, then random under three stall profiles).",
            items_sent);
        $display("Checked %0d rotated vectors, %0d of them saturated.", checked, ovf_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
